>>> src/wss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

	// Table geometry and field widths
	localparam int MAX_EVENTS = 64;
	localparam int IDX_W      = $clog2(MAX_EVENTS);
	localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
	localparam int TIME_W     = 20;
	localparam int SP_W       = 12;

	localparam int DAY_SECONDS = 24 * 60 * 60;
	localparam logic [TIME_W-1:0] WEEK_SECONDS = TIME_W'(7 * DAY_SECONDS);

	// Operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_CHECK   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NONE    = 2'd3
	} op_e;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_STEP,
		ST_READ_SP,
		ST_RESULT
	} state_e;

	typedef struct packed {
		logic [1:0]             operation;
		logic [TIME_W-1:0]      time_of_week;
		logic [5:0]             entry_index;
		logic [TIME_W-1:0]      entry_time;
		logic signed [SP_W-1:0] entry_setpoint;
	} in_item_t;

	typedef struct packed {
		logic signed [SP_W-1:0] setpoint;
		logic [5:0]             active_index;
		logic                   advance_in_effect;
	} out_item_t;

	// Shared access to the time and setpoint tables
	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic [TIME_W-1:0]      wtime;
		logic signed [SP_W-1:0] wsp;
		logic [IDX_W-1:0]       raddr;
	} mem_req_t;

	// Fold a time of one week or more back into the week
	function automatic logic [TIME_W-1:0] wrap_week(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] r;
		r = t;
		if (t >= WEEK_SECONDS) begin
			r = t - WEEK_SECONDS;
		end
		return r;
	endfunction

	// Number of events in use, clamped to 1..MAX_EVENTS
	function automatic logic [CNT_W-1:0] events_in_use(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] r;
		r = cnt;
		if (cnt == '0) begin
			r = CNT_W'(1);
		end else if (cnt > CNT_W'(MAX_EVENTS)) begin
			r = CNT_W'(MAX_EVENTS);
		end
		return r;
	endfunction

	// Following entry, wrapping at the event count
	function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] nx;
		logic [IDX_W-1:0] r;
		nx = CNT_W'(idx) + CNT_W'(1);
		r  = (nx >= n) ? '0 : nx[IDX_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/wss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wss_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/wss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wss_ctrl (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire wss_pkg::in_item_t                      in_data,
	input  wire logic                                   cfg_we,
	input  wire logic [wss_pkg::CNT_W-1:0]              cfg_data,
	output wss_pkg::mem_req_t                           mem_req,
	input  wire logic [wss_pkg::TIME_W-1:0]             time_rdata,
	input  wire logic signed [wss_pkg::SP_W-1:0]        sp_rdata,
	output logic                                        res_valid,
	input  wire logic                                   res_ready,
	output wss_pkg::out_item_t                          res_data
);
	import wss_pkg::*;

	state_e            state_q, state_d;
	logic [IDX_W-1:0]  cur_q;
	logic              known_q;
	logic [TIME_W-1:0] last_q;
	logic              adv_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  i_q;

	logic [CNT_W-1:0]  n;
	logic              in_fire;
	op_e               op;
	logic [IDX_W-1:0]  cur_fix;
	logic              srch_le;
	logic              srch_last;
	logic              srch_more;
	logic [IDX_W-1:0]  srch_idx;
	logic [IDX_W-1:0]  step_nx;
	logic [TIME_W:0]   t0, t1;
	logic              step_go;
	logic [IDX_W-1:0]  sp_idx;

	assign n       = events_in_use(cnt_q);
	assign in_fire = in_valid && !in_stall;
	assign op      = op_e'(in_data.operation);
	assign cur_fix = (CNT_W'(cur_q) >= n) ? '0 : cur_q;

	// Search compare: entry i_q read last cycle
	assign srch_le   = time_rdata <= now_q;
	assign srch_last = (CNT_W'(i_q) + CNT_W'(1)) == n;
	assign srch_more = srch_le && !srch_last;
	always_comb begin
		if (srch_le) begin
			srch_idx = i_q;
		end else if (i_q == '0) begin
			srch_idx = IDX_W'(n - CNT_W'(1));
		end else begin
			srch_idx = i_q - IDX_W'(1);
		end
	end

	// Step compare with Sunday-midnight rollover unwrapped
	assign step_nx = next_of(cur_q, n);
	assign t0 = {1'b0, now_q} + ((now_q < last_q) ? {1'b0, WEEK_SECONDS} : '0);
	assign t1 = {1'b0, time_rdata} + ((time_rdata < last_q) ? {1'b0, WEEK_SECONDS} : '0);
	assign step_go = t0 >= t1;

	// Entry whose setpoint is reported
	assign sp_idx = adv_q ? next_of(cur_q, n) : cur_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && op == OP_CHECK) begin
					state_d = known_q ? ST_STEP : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!srch_more) begin
					state_d = ST_READ_SP;
				end
			end
			ST_STEP:    state_d = ST_READ_SP;
			ST_READ_SP: state_d = ST_RESULT;
			ST_RESULT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs and memory port
	always_comb begin
		in_stall      = 1'b1;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = in_data.entry_index;
		mem_req.wtime = wrap_week(in_data.entry_time);
		mem_req.wsp   = in_data.entry_setpoint;
		mem_req.raddr = sp_idx;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				mem_req.we    = in_fire && op == OP_LOAD;
				mem_req.raddr = known_q ? next_of(cur_fix, n) : '0;
			end
			ST_SEARCH: begin
				mem_req.raddr = i_q + IDX_W'(1);
			end
			ST_STEP:    mem_req.raddr = sp_idx;
			ST_READ_SP: mem_req.raddr = sp_idx;
			ST_RESULT: begin
				res_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign res_data.setpoint          = sp_rdata;
	assign res_data.active_index      = cur_q;
	assign res_data.advance_in_effect = adv_q;

	// Schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			known_q <= 1'b0;
			last_q  <= '0;
			adv_q   <= 1'b0;
			cnt_q   <= CNT_W'(1);
			now_q   <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cnt_q   <= cfg_data;
				known_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (op)
							OP_CHECK: begin
								cur_q <= cur_fix;
								now_q <= wrap_week(in_data.time_of_week);
								i_q   <= '0;
							end
							OP_LOAD:    known_q <= 1'b0;
							OP_ADVANCE: adv_q   <= 1'b1;
							OP_NONE:    ;
						endcase
					end
				end
				ST_SEARCH: begin
					if (srch_more) begin
						i_q <= i_q + IDX_W'(1);
					end else begin
						cur_q   <= srch_idx;
						known_q <= 1'b1;
						adv_q   <= 1'b0;
						last_q  <= now_q;
					end
				end
				ST_STEP: begin
					if (step_go) begin
						cur_q <= step_nx;
						adv_q <= 1'b0;
					end
					last_q <= now_q;
				end
				ST_READ_SP: ;
				ST_RESULT:  ;
				default:    ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/weekly_setpoint_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Weekly setpoint scheduler. Event times and setpoints sit in two 64-entry
// synchronous tables, loaded by load transactions (any load, or a write of
// event_count, forces a fresh search on the next time check). A time check
// returns one result: the setpoint in force, the current event index and the
// advance flag; loads, advance requests and operation 3 return nothing. A
// time check that follows the last check without a load passes through the
// step, setpoint read and result states. The first check after a load walks
// the time table one entry per cycle through its single read port, over at
// most the number of events in use (event_count clamped to 1..64). Output
// stalls can hold a result back. Results leave through an output register,
// so a transaction may be accepted while a result waits.
module weekly_setpoint_scheduler_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire wss_pkg::in_item_t         in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output wss_pkg::out_item_t             out_data,
	input  wire logic                      cfg_we,
	input  wire logic [wss_pkg::CNT_W-1:0] cfg_data
);
	import wss_pkg::*;

	mem_req_t               mem_req;
	logic [TIME_W-1:0]      time_rdata;
	logic [SP_W-1:0]        sp_rdata;
	logic                   res_valid;
	logic                   res_ready;
	out_item_t              res_data;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	// Event time table
	wss_ram #(
		.DATA_W (TIME_W),
		.DEPTH  (MAX_EVENTS)
	) u_time_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wtime),
		.raddr (mem_req.raddr),
		.rdata (time_rdata)
	);

	// Setpoint table
	wss_ram #(
		.DATA_W (SP_W),
		.DEPTH  (MAX_EVENTS)
	) u_sp_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wsp),
		.raddr (mem_req.raddr),
		.rdata (sp_rdata)
	);

	wss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mem_req    (mem_req),
		.time_rdata (time_rdata),
		.sp_rdata   ($signed(sp_rdata)),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	// Output register
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// A result held back by a full output register stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while held");

	// Tables are written only by an accepted transaction
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> in_valid && !in_stall)
		else $error("table write without accepted transaction");

	// A time check always occupies the controller after acceptance
	a_check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.operation == OP_CHECK |=> in_stall)
		else $error("time check did not occupy controller");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import wss_pkg::*;

	localparam int unsigned WEEK          = 7 * 24 * 60 * 60;
	localparam int unsigned TIME_SPAN     = 1 << TIME_W;
	localparam int unsigned RANDOM_ITEMS  = 1150;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned IDLE_LIMIT    = 2000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;

	weekly_setpoint_scheduler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Schedule predictor state
	int unsigned      ev_time [MAX_EVENTS];
	logic signed [SP_W-1:0] ev_sp [MAX_EVENTS];
	int unsigned      cur_event   = 0;
	bit               event_known = 1'b0;
	int unsigned      prev_check  = 0;
	bit               advance_on  = 1'b0;
	int unsigned      count_reg   = 1;
	out_item_t        setpoints_due [$];

	// Run statistics
	int unsigned n_checks   = 0;
	int unsigned n_loads    = 0;
	int unsigned n_advances = 0;
	int unsigned n_counts   = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;

	// Sender burst state, receiver stall pattern, watchdog
	int unsigned burst_left = 0;
	bit          stall_on   = 1'b0;
	int unsigned stall_run  = 0;
	int unsigned idle_cycles = 0;

	function automatic int unsigned fold_week(input int unsigned t);
		return (t >= WEEK) ? t - WEEK : t;
	endfunction

	function automatic int unsigned events_used(input int unsigned c);
		if (c == 0) return 1;
		if (c > MAX_EVENTS) return MAX_EVENTS;
		return c;
	endfunction

	function automatic int unsigned following(input int unsigned idx, input int unsigned n);
		return (idx + 1 >= n) ? 0 : idx + 1;
	endfunction

	function automatic int unsigned rand_time();
		return $urandom_range(0, TIME_SPAN - 1);
	endfunction

	// Mostly in the documented range, now and then anywhere in 12 bits
	function automatic int rand_setpoint();
		if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 4095)) - 2048;
		return int'($urandom_range(0, 2240)) - 640;
	endfunction

	function automatic in_item_t make_item(input op_e op, input int unsigned tow,
			input int unsigned idx, input int unsigned etime, input int sp);
		in_item_t it;
		it.operation      = op;
		it.time_of_week   = TIME_W'(tow);
		it.entry_index    = 6'(idx);
		it.entry_time     = TIME_W'(etime);
		it.entry_setpoint = SP_W'(sp);
		return it;
	endfunction

	// Advance the schedule by one accepted transaction, queue a time check's result
	task automatic track_schedule(input in_item_t it);
		int unsigned n, now, i, nx, t0, t1, pick;
		out_item_t r;
		n = events_used(count_reg);
		case (op_e'(it.operation))
			OP_LOAD: begin
				ev_time[it.entry_index] = fold_week(it.entry_time);
				ev_sp[it.entry_index]   = it.entry_setpoint;
				event_known = 1'b0;
				n_loads++;
			end
			OP_ADVANCE: begin
				advance_on = 1'b1;
				n_advances++;
			end
			OP_CHECK: begin
				now = fold_week(it.time_of_week);
				if (cur_event >= n) cur_event = 0;
				if (!event_known) begin
					// last event at or before now, else the final entry
					i = 0;
					while (i < n && ev_time[i] <= now) i++;
					cur_event   = (i == 0) ? n - 1 : i - 1;
					event_known = 1'b1;
					advance_on  = 1'b0;
				end else begin
					// step once, unwrapping the Sunday rollover
					nx = following(cur_event, n);
					t0 = now;
					t1 = ev_time[nx];
					if (t0 < prev_check) t0 += WEEK;
					if (t1 < prev_check) t1 += WEEK;
					if (t0 >= t1) begin
						cur_event  = nx;
						advance_on = 1'b0;
					end
				end
				prev_check = now;
				pick = advance_on ? following(cur_event, n) : cur_event;
				r.setpoint          = ev_sp[pick];
				r.active_index      = 6'(cur_event);
				r.advance_in_effect = advance_on;
				setpoints_due.push_back(r);
				n_checks++;
			end
			default: ;
		endcase
	endtask

	// Send one transaction, with bursts and random gaps
	task automatic send_item(input in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(40, 160);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(1, 8);
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		track_schedule(it);
	endtask

	task automatic do_check(input int unsigned tow);
		send_item(make_item(OP_CHECK, tow, $urandom_range(0, 63), rand_time(), rand_setpoint()));
	endtask

	task automatic do_load(input int unsigned idx, input int unsigned etime, input int sp);
		send_item(make_item(OP_LOAD, rand_time(), idx, etime, sp));
	endtask

	task automatic do_advance();
		send_item(make_item(OP_ADVANCE, rand_time(), $urandom_range(0, 63), rand_time(),
			rand_setpoint()));
	endtask

	task automatic do_unused_op();
		send_item(make_item(OP_NONE, rand_time(), $urandom_range(0, 63), rand_time(),
			rand_setpoint()));
	endtask

	// Hold the sender until every queued result is out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (setpoints_due.size() != 0);
	endtask

	// Drain, then allow a quiet transaction's worst latency to pass
	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input int unsigned value);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= CNT_W'(value);
		@(posedge clk);
		cfg_we   <= 1'b0;
		count_reg   = value;
		event_known = 1'b0;
		n_counts++;
	endtask

	// Reset count of one event
	task automatic test_reset_count();
		do_load(0, 3600, 1600);
		do_check(0);
		do_check(WEEK - 1);
	endtask

	// Count zero acts as one; time past a week folds back
	task automatic test_count_zero();
		write_count(0);
		do_load(0, 0, -640);
		do_check(TIME_SPAN - 1);
	endtask

	// Search, single steps and Sunday rollover on three events
	task automatic test_search_and_step();
		write_count(3);
		do_load(0, 100, 320);
		do_load(1, 200000 + WEEK, -640);
		do_load(2, 500000, 1600);
		do_check(50);
		do_check(150);
		do_check(WEEK - 1);
		do_check(10);
	endtask

	// Advance with a known index, cleared at the boundary and by a search
	task automatic test_advance();
		do_advance();
		do_check(20);
		do_check(500000);
		do_load(1, 200000, 2047);
		do_advance();
		do_check(250000);
		do_advance();
		do_check(250001);
	endtask

	// Unused operation, unsorted table, count rewrite forcing a search
	task automatic test_quiet_and_unsorted();
		do_unused_op();
		do_check(250002);
		do_load(0, 550000, -2048);
		do_check(300000);
		write_count(3);
		do_check(40);
	endtask

	// Phases of table size, mostly sorted loads, then a walking time stream
	task automatic test_random_schedules();
		int unsigned sent, phase, cnt, n, et, t, hop, r, checks;
		int unsigned times [$];
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: cnt = MAX_EVENTS;
				1: cnt = 127;
				2: cnt = 2;
				3: cnt = MAX_EVENTS + 1;
				default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
					: $urandom_range(1, 8);
			endcase
			phase++;
			write_count(cnt);
			n = events_used(cnt);

			times.delete();
			for (int unsigned i = 0; i < n; i++) times.push_back($urandom_range(0, WEEK - 1));
			if ($urandom_range(0, 5) != 0) times.sort();
			for (int unsigned i = 0; i < n; i++) begin
				et = times[i];
				if (et < TIME_SPAN - WEEK && $urandom_range(0, 7) == 0) et += WEEK;
				do_load(i, et, rand_setpoint());
				sent++;
			end

			t = $urandom_range(0, WEEK - 1);
			checks = $urandom_range(20, 80);
			repeat (checks) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					do_advance();
					sent++;
				end else if (r < 11) begin
					do_unused_op();
				end else if (r < 14) begin
					do_load($urandom_range(0, 63), rand_time(), rand_setpoint());
					sent++;
				end else if (r < 16) begin
					wait_for_results();
				end else if (r < 19) begin
					t = $urandom_range(0, WEEK - 1);
				end
				hop = (r < 30) ? 0 : $urandom_range(0, 2 * WEEK / n);
				t = (t + hop) % WEEK;
				do_check((t < TIME_SPAN - WEEK && $urandom_range(0, 9) == 0) ? t + WEEK : t);
				sent++;
			end
		end
	endtask

	// Receiver stall pattern: alternating runs of stall and flow
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_on = !stall_on;
			if (stall_on) stall_run = $urandom_range(1, 10);
			else if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(30, 120);
			else stall_run = $urandom_range(1, 6);
		end
		stall_run--;
		out_stall <= stall_on;
	end

	task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected sp=%0d idx=%0d adv=%0b, got sp=%0d idx=%0d adv=%0b",
				$realtime, what, want.setpoint, want.active_index, want.advance_in_effect,
				got.setpoint, got.active_index, got.advance_in_effect);
	endtask

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (setpoints_due.size() == 0) begin
				note_mismatch("result with nothing pending", '0, out_data);
			end else begin
				want = setpoints_due.pop_front();
				if (out_data.setpoint !== want.setpoint
						|| out_data.active_index !== want.active_index
						|| out_data.advance_in_effect !== want.advance_in_effect)
					note_mismatch("result mismatch", want, out_data);
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_count_zero();
		test_search_and_step();
		test_advance();
		test_quiet_and_unsorted();
		test_random_schedules();
		settle();
		$display("Ran %0d time checks, %0d loads, %0d advance requests, %0d event_count writes",
			n_checks, n_loads, n_advances, n_counts);
		$display("Compared %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
